FILE: design/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants of the indexed min-heap
// Sizes, command codes, controller states, datapath ops and status flags.
// ----------------------------------------------------------------------------
package imh_pkg;

   localparam int NODES  = 256;
   localparam int NODE_W = 8;
   localparam int SLOT_W = $clog2(NODES);
   localparam int KEY_W  = 32;
   localparam int CNT_W  = SLOT_W + 1;

   localparam logic [1:0] CMD_INSERT   = 2'd0;
   localparam logic [1:0] CMD_DECREASE = 2'd1;
   localparam logic [1:0] CMD_EXTRACT  = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_HELD1, ST_HELD2,
      ST_UP, ST_UP_KEY, ST_UP_CMP, ST_PLACE,
      ST_MIN_RD, ST_MIN_KEY, ST_MIN_OUT,
      ST_EX_TAKE, ST_EX_LAST, ST_EX_MV,
      ST_DN, ST_DN_KL, ST_DN_LQ, ST_DN_KR, ST_DN_RQ, ST_DN_CMP,
      ST_EMIT
   } imh_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_LOOKUP, OP_HELD_RD, OP_LOWER, OP_APPEND, OP_FULL,
      OP_UP_RD, OP_UP_KEY, OP_UP_SWAP, OP_PLACE,
      OP_MIN_RD, OP_MIN_KEY, OP_EMIT_MIN,
      OP_EX_ROOT, OP_EX_TAKE, OP_EX_LAST, OP_EX_MV,
      OP_DN_RDL, OP_DN_KL, OP_DN_LQ, OP_DN_KR, OP_DN_RQ, OP_DN_SWAP,
      OP_EMIT_TAKEN
   } imh_op_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       count_zero;
      logic       held;
      logic       lower;
      logic       full;
      logic       s_zero;
      logic       up_less;
      logic       l_out;
      logic       r_in;
      logic       dn_more;
   } imh_flags_type;

endpackage

FILE: design/imh_ctrl.sv
// ----------------------------------------------------------------------------
// imh_ctrl: heap command sequencer
// Walks insert, decrease-key and extract through the datapath one op a cycle.
// ----------------------------------------------------------------------------
module imh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  imh_pkg::imh_flags_type flags,
   output imh_pkg::imh_op_type    op,
   output logic                   busy
);

   imh_pkg::imh_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != imh_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      op       = imh_pkg::OP_NONE;
      case (state_ff)
         imh_pkg::ST_IDLE: begin
            if (start) begin
               op       = imh_pkg::OP_LATCH;
               state_in = imh_pkg::ST_DECODE;
            end
         end
         imh_pkg::ST_DECODE: begin
            if (flags.cmd == imh_pkg::CMD_EXTRACT) begin
               if (flags.count_zero) begin
                  state_in = imh_pkg::ST_MIN_RD;
               end else begin
                  op       = imh_pkg::OP_EX_ROOT;
                  state_in = imh_pkg::ST_EX_TAKE;
               end
            end else if (flags.cmd inside {imh_pkg::CMD_INSERT,
                                           imh_pkg::CMD_DECREASE}) begin
               op       = imh_pkg::OP_LOOKUP;
               state_in = imh_pkg::ST_HELD1;
            end else begin
               state_in = imh_pkg::ST_MIN_RD;
            end
         end
         imh_pkg::ST_HELD1: begin
            op       = imh_pkg::OP_HELD_RD;
            state_in = imh_pkg::ST_HELD2;
         end
         imh_pkg::ST_HELD2: begin
            state_in = imh_pkg::ST_MIN_RD;
            if (flags.held) begin
               if (flags.lower) begin
                  op       = imh_pkg::OP_LOWER;
                  state_in = imh_pkg::ST_UP;
               end
            end else if (flags.cmd == imh_pkg::CMD_INSERT) begin
               if (flags.full) begin
                  op = imh_pkg::OP_FULL;
               end else begin
                  op       = imh_pkg::OP_APPEND;
                  state_in = imh_pkg::ST_UP;
               end
            end
         end
         imh_pkg::ST_UP: begin
            if (flags.s_zero) begin
               state_in = imh_pkg::ST_PLACE;
            end else begin
               op       = imh_pkg::OP_UP_RD;
               state_in = imh_pkg::ST_UP_KEY;
            end
         end
         imh_pkg::ST_UP_KEY: begin
            op       = imh_pkg::OP_UP_KEY;
            state_in = imh_pkg::ST_UP_CMP;
         end
         imh_pkg::ST_UP_CMP: begin
            if (flags.up_less) begin
               op       = imh_pkg::OP_UP_SWAP;
               state_in = imh_pkg::ST_UP;
            end else begin
               state_in = imh_pkg::ST_PLACE;
            end
         end
         imh_pkg::ST_PLACE: begin
            op       = imh_pkg::OP_PLACE;
            state_in = (flags.cmd == imh_pkg::CMD_EXTRACT) ? imh_pkg::ST_EMIT
                                                           : imh_pkg::ST_MIN_RD;
         end
         imh_pkg::ST_MIN_RD: begin
            op       = imh_pkg::OP_MIN_RD;
            state_in = imh_pkg::ST_MIN_KEY;
         end
         imh_pkg::ST_MIN_KEY: begin
            op       = imh_pkg::OP_MIN_KEY;
            state_in = imh_pkg::ST_MIN_OUT;
         end
         imh_pkg::ST_MIN_OUT: begin
            op       = imh_pkg::OP_EMIT_MIN;
            state_in = imh_pkg::ST_IDLE;
         end
         imh_pkg::ST_EX_TAKE: begin
            op       = imh_pkg::OP_EX_TAKE;
            state_in = imh_pkg::ST_EX_LAST;
         end
         imh_pkg::ST_EX_LAST: begin
            op       = imh_pkg::OP_EX_LAST;
            state_in = flags.count_zero ? imh_pkg::ST_EMIT : imh_pkg::ST_EX_MV;
         end
         imh_pkg::ST_EX_MV: begin
            op       = imh_pkg::OP_EX_MV;
            state_in = imh_pkg::ST_DN;
         end
         imh_pkg::ST_DN: begin
            if (flags.l_out) begin
               state_in = imh_pkg::ST_PLACE;
            end else begin
               op       = imh_pkg::OP_DN_RDL;
               state_in = imh_pkg::ST_DN_KL;
            end
         end
         imh_pkg::ST_DN_KL: begin
            op       = imh_pkg::OP_DN_KL;
            state_in = imh_pkg::ST_DN_LQ;
         end
         imh_pkg::ST_DN_LQ: begin
            op       = imh_pkg::OP_DN_LQ;
            state_in = flags.r_in ? imh_pkg::ST_DN_KR : imh_pkg::ST_DN_CMP;
         end
         imh_pkg::ST_DN_KR: begin
            op       = imh_pkg::OP_DN_KR;
            state_in = imh_pkg::ST_DN_RQ;
         end
         imh_pkg::ST_DN_RQ: begin
            op       = imh_pkg::OP_DN_RQ;
            state_in = imh_pkg::ST_DN_CMP;
         end
         imh_pkg::ST_DN_CMP: begin
            if (flags.dn_more) begin
               op       = imh_pkg::OP_DN_SWAP;
               state_in = imh_pkg::ST_DN;
            end else begin
               state_in = imh_pkg::ST_PLACE;
            end
         end
         imh_pkg::ST_EMIT: begin
            op       = imh_pkg::OP_EMIT_TAKEN;
            state_in = imh_pkg::ST_IDLE;
         end
         default: begin
            state_in = imh_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/imh_dp.sv
// ----------------------------------------------------------------------------
// imh_dp: heap datapath
// Slot, key and node-to-slot memories, the sift registers and the result beat.
// ----------------------------------------------------------------------------
module imh_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  imh_pkg::imh_op_type          op,
   input  logic [1:0]                   req_cmd,
   input  logic [imh_pkg::NODE_W-1:0]   req_node_id,
   input  logic [imh_pkg::KEY_W-1:0]    req_key_value,
   output imh_pkg::imh_flags_type       flags,
   output logic                         rsp_strobe,
   output logic [imh_pkg::NODE_W-1:0]   rsp_min_node,
   output logic [imh_pkg::KEY_W-1:0]    rsp_min_key,
   output logic [imh_pkg::CNT_W-1:0]    rsp_entry_total,
   output logic [1:0]                   rsp_status
);

   localparam int SW = imh_pkg::SLOT_W;
   localparam int NW = imh_pkg::NODE_W;
   localparam int KW = imh_pkg::KEY_W;
   localparam int CW = imh_pkg::CNT_W;

   // memories
   logic [NW-1:0] heap_slots   [imh_pkg::NODES];
   logic [KW-1:0] node_key     [imh_pkg::NODES];
   logic [SW-1:0] slot_of_node [imh_pkg::NODES];

   logic [NW-1:0] hs_q;
   logic [KW-1:0] nk_q;
   logic [SW-1:0] sn_q;

   logic [SW-1:0] hs_ra, hs_wa;
   logic [NW-1:0] hs_wd;
   logic          hs_we;
   logic [NW-1:0] nk_ra;
   logic          nk_we;

   // sift state
   logic [1:0]    cmd_ff;
   logic [NW-1:0] node_ff, mv_node_ff, b_node_ff, c_node_ff, r_node_ff, taken_node_ff;
   logic [KW-1:0] key_ff, old_key_ff, mv_key_ff, c_key_ff, taken_key_ff;
   logic [SW-1:0] s_ff, c_slot_ff;
   logic [NW-1:0] res_node_ff;
   logic [CW-1:0] count_ff;
   logic [1:0]    status_ff;
   logic          strobe_ff;
   logic [NW-1:0] out_node_ff;
   logic [KW-1:0] out_key_ff;
   logic [CW-1:0] out_total_ff;
   logic [1:0]    out_status_ff;

   logic [SW-1:0] p_slot;
   logic [CW-1:0] l_slot;
   logic [CW:0]   r_slot;
   logic [CW-1:0] count_less;

   assign p_slot     = (s_ff - SW'(1)) >> 1;
   assign l_slot     = {s_ff, 1'b1};
   assign r_slot     = {1'b0, l_slot} + (CW+1)'(1);
   assign count_less = count_ff - CW'(1);

   assign flags.cmd        = cmd_ff;
   assign flags.count_zero = (count_ff == '0);
   assign flags.held       = ({1'b0, s_ff} < count_ff) && (hs_q == node_ff);
   assign flags.lower      = (key_ff < old_key_ff);
   assign flags.full       = (count_ff == CW'(imh_pkg::NODES));
   assign flags.s_zero     = (s_ff == '0);
   assign flags.up_less    = (mv_key_ff < nk_q);
   assign flags.l_out      = (l_slot >= count_ff);
   assign flags.r_in       = (r_slot < {1'b0, count_ff});
   assign flags.dn_more    = (mv_key_ff > c_key_ff);

   // memory port selection
   always_comb begin
      hs_ra = '0;
      hs_we = 1'b0;
      hs_wa = s_ff;
      hs_wd = mv_node_ff;
      nk_ra = hs_q;
      nk_we = 1'b0;
      case (op)
         imh_pkg::OP_LOOKUP:   nk_ra = node_ff;
         imh_pkg::OP_HELD_RD:  hs_ra = sn_q;
         imh_pkg::OP_LOWER,
         imh_pkg::OP_APPEND:   nk_we = 1'b1;
         imh_pkg::OP_UP_RD:    hs_ra = p_slot;
         imh_pkg::OP_UP_SWAP: begin
            hs_we = 1'b1;
            hs_wd = b_node_ff;
         end
         imh_pkg::OP_PLACE:    hs_we = 1'b1;
         imh_pkg::OP_EX_TAKE:  hs_ra = count_less[SW-1:0];
         imh_pkg::OP_DN_RDL:   hs_ra = l_slot[SW-1:0];
         imh_pkg::OP_DN_LQ:    hs_ra = r_slot[SW-1:0];
         imh_pkg::OP_DN_SWAP: begin
            hs_we = 1'b1;
            hs_wd = c_node_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (hs_we) begin
         heap_slots[hs_wa]   <= hs_wd;
         slot_of_node[hs_wd] <= hs_wa;
      end
      if (nk_we) begin
         node_key[node_ff] <= key_ff;
      end
      hs_q <= heap_slots[hs_ra];
      nk_q <= node_key[nk_ra];
      sn_q <= slot_of_node[node_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (op == imh_pkg::OP_EMIT_MIN) || (op == imh_pkg::OP_EMIT_TAKEN);
         if (op == imh_pkg::OP_APPEND) begin
            count_ff <= count_ff + CW'(1);
         end else if (op == imh_pkg::OP_EX_TAKE) begin
            count_ff <= count_less;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (op)
         imh_pkg::OP_LATCH: begin
            cmd_ff    <= req_cmd;
            node_ff   <= req_node_id;
            key_ff    <= req_key_value;
            status_ff <= imh_pkg::STAT_OK;
         end
         imh_pkg::OP_HELD_RD: begin
            s_ff       <= sn_q;
            old_key_ff <= nk_q;
         end
         imh_pkg::OP_LOWER: begin
            mv_node_ff <= node_ff;
            mv_key_ff  <= key_ff;
         end
         imh_pkg::OP_APPEND: begin
            mv_node_ff <= node_ff;
            mv_key_ff  <= key_ff;
            s_ff       <= count_ff[SW-1:0];
         end
         imh_pkg::OP_FULL:     status_ff <= imh_pkg::STAT_FULL;
         imh_pkg::OP_UP_KEY:   b_node_ff <= hs_q;
         imh_pkg::OP_UP_SWAP:  s_ff      <= p_slot;
         imh_pkg::OP_MIN_KEY:  res_node_ff <= hs_q;
         imh_pkg::OP_EMIT_MIN: begin
            if (count_ff == '0) begin
               out_node_ff   <= '0;
               out_key_ff    <= '0;
               out_status_ff <= (status_ff == imh_pkg::STAT_OK) ? imh_pkg::STAT_EMPTY
                                                                : status_ff;
            end else begin
               out_node_ff   <= res_node_ff;
               out_key_ff    <= nk_q;
               out_status_ff <= status_ff;
            end
            out_total_ff <= count_ff;
         end
         imh_pkg::OP_EX_TAKE:  taken_node_ff <= hs_q;
         imh_pkg::OP_EX_LAST: begin
            taken_key_ff <= nk_q;
            mv_node_ff   <= hs_q;
         end
         imh_pkg::OP_EX_MV: begin
            mv_key_ff <= nk_q;
            s_ff      <= '0;
         end
         imh_pkg::OP_DN_KL: begin
            c_node_ff <= hs_q;
            c_slot_ff <= l_slot[SW-1:0];
         end
         imh_pkg::OP_DN_LQ:    c_key_ff  <= nk_q;
         imh_pkg::OP_DN_KR:    r_node_ff <= hs_q;
         imh_pkg::OP_DN_RQ: begin
            if (nk_q < c_key_ff) begin
               c_node_ff <= r_node_ff;
               c_key_ff  <= nk_q;
               c_slot_ff <= r_slot[SW-1:0];
            end
         end
         imh_pkg::OP_DN_SWAP:  s_ff <= c_slot_ff;
         imh_pkg::OP_EMIT_TAKEN: begin
            out_node_ff   <= taken_node_ff;
            out_key_ff    <= taken_key_ff;
            out_total_ff  <= count_ff;
            out_status_ff <= imh_pkg::STAT_OK;
         end
         default: ;
      endcase
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_min_node    = out_node_ff;
   assign rsp_min_key     = out_key_ff;
   assign rsp_entry_total = out_total_ff;
   assign rsp_status      = out_status_ff;

endmodule

FILE: design/indexed_min_heap_unit.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_unit: indexed binary min-heap with decrease-key
// Priority queue of node ids keyed per node, with a node-to-slot map.
// ----------------------------------------------------------------------------
// Use: drive req_cmd / req_node_id / req_key_value and raise start; the beat
// is taken on an edge where start is high and busy is low. Commands are
// insert (a held node is treated as decrease-key), decrease-key and
// extract-min. Exactly one result beat follows each command, shown for one
// cycle with rsp_strobe high; the receiver cannot stall it.
// A sequencer issues one memory op a cycle against slot, key and map
// memories, each with one read port, one write port and registered reads.
// A sift-up level steps through ST_UP, ST_UP_KEY and ST_UP_CMP; a sift-down
// level through ST_DN, ST_DN_KL, ST_DN_LQ, ST_DN_KR and ST_DN_RQ (these two
// only with a right child) and ST_DN_CMP. The unused code and an empty
// extract skip the sifts; else the wait for the result beat grows with the
// levels sifted, bounded by the tree depth. busy stays high from acceptance
// until the result beat issues, so the next command can be taken on the edge that ends the beat.
// Reset clears only the entry count and the control state; the memories
// are never cleared, a node counts as held only when its mapped slot is
// below the count and that slot points back at it.
// ----------------------------------------------------------------------------
module indexed_min_heap_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_cmd,
   input  logic [imh_pkg::NODE_W-1:0]    req_node_id,
   input  logic [imh_pkg::KEY_W-1:0]     req_key_value,
   output logic                          rsp_strobe,
   output logic [imh_pkg::NODE_W-1:0]    rsp_min_node,
   output logic [imh_pkg::KEY_W-1:0]     rsp_min_key,
   output logic [imh_pkg::CNT_W-1:0]     rsp_entry_total,
   output logic [1:0]                    rsp_status
);

   imh_pkg::imh_op_type    op;
   imh_pkg::imh_flags_type flags;

   // sequencer: one datapath op per cycle
   imh_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .op    (op),
      .busy  (busy)
   );

   // memories, sift registers and result beat
   imh_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .req_cmd         (req_cmd),
      .req_node_id     (req_node_id),
      .req_key_value   (req_key_value),
      .flags           (flags),
      .rsp_strobe      (rsp_strobe),
      .rsp_min_node    (rsp_min_node),
      .rsp_min_key     (rsp_min_key),
      .rsp_entry_total (rsp_entry_total),
      .rsp_status      (rsp_status)
   );

endmodule
